// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the Kosinski decompressor modules.
// No dependencies; included by every module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KLZ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("klz assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KLZ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("klz assertion failed");

`endif

// ===== hdl/klz_pkg.sv =====
// Shared types and constants of the Kosinski decompressor.
// No dependencies; imported by the parser, the copy engine and the top level.
package klz_pkg;

  // History window addressing and token field widths.
  localparam int WIN_AW = 13;
  localparam int WIN_SIZE = 1 << WIN_AW;
  localparam int LEN_W = 9;

  // Result packing.
  localparam int BYTES_PER_RESULT = 4;
  localparam int FILL_W = 2;
  localparam int COUNT_W = 3;

  // Default queue depths.
  localparam int CMD_DEPTH_DEFAULT = 2;
  localparam int RES_DEPTH_DEFAULT = 2;

  // Commands passed from the parser to the copy engine.
  typedef enum logic [1:0] {
    CMD_LIT  = 2'd0,
    CMD_COPY = 2'd1,
    CMD_END  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic [WIN_AW-1:0] offset;
    logic [LEN_W-1:0]  length;
  } cmd_t;

  // One packed result item.
  typedef struct packed {
    logic [BYTES_PER_RESULT-1:0][7:0] data;
    logic [COUNT_W-1:0]               count;
    logic                             last;
    logic                             stream_end;
  } res_t;

endpackage

// ===== hdl/klz_fifo.sv =====
// Small synchronous queue used between the parser, the copy engine and the output.
// No package dependency; uses the assertion macros of assert_macros.svh.
`include "assert_macros.svh"

module klz_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  // Handshake qualification; a push into a full queue is ignored.
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `KLZ_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `KLZ_ASSERT_NEXT(a_count_up, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1)
  `KLZ_ASSERT_NEXT(a_count_down, clk, rst, do_pop && !do_push, count == $past(count) - 1'b1)

endmodule

// ===== hdl/klz_front.sv =====
// Stream parser: takes compressed bytes, tracks the flag word and emits commands.
// Depends on klz_pkg and on the assertion macros of assert_macros.svh.
`include "assert_macros.svh"

module klz_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    in_byte,
  output logic          full,
  input  logic          cmd_full,
  output logic          cmd_push,
  output klz_pkg::cmd_t cmd
);

  import klz_pkg::*;

  // Parse phases, one-hot.
  typedef enum logic [6:0] {
    PH_DLO   = 7'b0000001,
    PH_DHI   = 7'b0000010,
    PH_LIT   = 7'b0000100,
    PH_FULL1 = 7'b0001000,
    PH_FULL2 = 7'b0010000,
    PH_FULLX = 7'b0100000,
    PH_INLD  = 7'b1000000
  } phase_t;

  // Resume points of the flag decoder, kept in the held byte across a refill.
  localparam logic [7:0] RS_TOKEN = 8'd0;
  localparam logic [7:0] RS_BIT2  = 8'd1;
  localparam logic [7:0] RS_BIT3  = 8'd2;
  localparam logic [7:0] RS_BIT4  = 8'd3;
  localparam logic [7:0] RS_LIT   = 8'd4;
  localparam logic [7:0] RS_FULL  = 8'd5;
  localparam logic [7:0] RS_INL   = 8'd6;

  typedef struct packed {
    logic [15:0] flag_word;
    logic [4:0]  flags_left;
    phase_t      phase;
    logic [7:0]  held;
    logic [2:0]  inl_len;
  } parse_t;

  // Walk the flag bits from a resume point until a token needs a byte or the
  // flag word runs dry. At most four bits are used per call.
  function automatic parse_t decode(input logic [7:0] start, input parse_t cur);
    parse_t     d;
    logic [7:0] at;
    logic [7:0] nxt;
    logic       flag;
    logic       done;
    d    = cur;
    at   = start;
    done = 1'b0;
    for (int i = 0; i < 5; i++) begin
      if (!done) begin
        flag = d.flag_word[0];
        nxt  = RS_TOKEN;
        unique case (at)
          RS_LIT: begin
            d.phase = PH_LIT;
            done    = 1'b1;
          end
          RS_FULL: begin
            d.phase = PH_FULL1;
            done    = 1'b1;
          end
          RS_INL: begin
            d.phase = PH_INLD;
            done    = 1'b1;
          end
          RS_BIT2: begin
            if (flag) begin
              nxt = RS_FULL;
            end else begin
              d.inl_len = 3'd2;
              nxt       = RS_BIT3;
            end
          end
          RS_BIT3: begin
            if (flag) begin
              d.inl_len = d.inl_len + 3'd2;
            end
            nxt = RS_BIT4;
          end
          RS_BIT4: begin
            if (flag) begin
              d.inl_len = d.inl_len + 3'd1;
            end
            nxt = RS_INL;
          end
          default: begin
            nxt = flag ? RS_LIT : RS_BIT2;
          end
        endcase
        if (!done) begin
          d.flag_word = {1'b0, d.flag_word[15:1]};
          if (d.flags_left != 5'd0) begin
            d.flags_left = d.flags_left - 5'd1;
          end
          if (d.flags_left == 5'd0) begin
            d.held  = nxt;
            d.phase = PH_DLO;
            done    = 1'b1;
          end else begin
            at = nxt;
          end
        end
      end
    end
    return d;
  endfunction

  parse_t            st;
  parse_t            st_next;
  parse_t            refill;
  logic [WIN_AW-1:0] offset;
  logic [WIN_AW-1:0] offset_next;
  logic              accept;

  // The parser stalls only when the command queue cannot take a command.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // Per-byte parse step.
  always_comb begin
    st_next     = st;
    offset_next = offset;
    cmd_push    = 1'b0;
    cmd         = '0;
    refill      = st;
    if (accept) begin
      unique case (st.phase)
        PH_DLO: begin
          st_next.flag_word = {8'h00, in_byte};
          st_next.phase     = PH_DHI;
        end
        PH_DHI: begin
          refill.flag_word  = {in_byte, st.flag_word[7:0]};
          refill.flags_left = 5'd16;
          st_next           = decode(st.held, refill);
        end
        PH_LIT: begin
          cmd_push = 1'b1;
          cmd.kind = CMD_LIT;
          cmd.data = in_byte;
          st_next  = decode(RS_TOKEN, st);
        end
        PH_FULL1: begin
          st_next.held  = in_byte;
          st_next.phase = PH_FULL2;
        end
        PH_FULL2: begin
          offset_next = {in_byte[7:3], st.held};
          if (in_byte[2:0] != 3'd0) begin
            cmd_push   = 1'b1;
            cmd.kind   = CMD_COPY;
            cmd.offset = offset_next;
            cmd.length = {6'd0, in_byte[2:0]} + 9'd2;
            st_next    = decode(RS_TOKEN, st);
          end else begin
            st_next.phase = PH_FULLX;
          end
        end
        PH_FULLX: begin
          if (in_byte == 8'd0) begin
            // Terminator: await a fresh flag word.
            cmd_push           = 1'b1;
            cmd.kind           = CMD_END;
            st_next.flags_left = 5'd0;
            st_next.flag_word  = 16'h0000;
            st_next.held       = RS_TOKEN;
            st_next.phase      = PH_DLO;
          end else if (in_byte == 8'd1) begin
            // Dummy token, nothing to copy.
            st_next = decode(RS_TOKEN, st);
          end else begin
            cmd_push   = 1'b1;
            cmd.kind   = CMD_COPY;
            cmd.offset = offset;
            cmd.length = {1'b0, in_byte} + 9'd1;
            st_next    = decode(RS_TOKEN, st);
          end
        end
        PH_INLD: begin
          offset_next = {5'h1F, in_byte};
          cmd_push    = 1'b1;
          cmd.kind    = CMD_COPY;
          cmd.offset  = offset_next;
          cmd.length  = {6'd0, st.inl_len};
          st_next     = decode(RS_TOKEN, st);
        end
        default: begin
          st_next.flags_left = 5'd0;
          st_next.held       = RS_TOKEN;
          st_next.phase      = PH_DLO;
        end
      endcase
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.flag_word  <= 16'h0000;
      st.flags_left <= 5'd0;
      st.phase      <= PH_DLO;
      st.held       <= RS_TOKEN;
      st.inl_len    <= 3'd0;
    end else begin
      st <= st_next;
    end
  end

  // Match distance, held between the bytes of a full match.
  always_ff @(posedge clk) begin
    offset <= offset_next;
  end

  `KLZ_ASSERT_SAME(a_lit_cmd, clk, rst, accept && st.phase == PH_LIT, cmd_push && cmd.kind == CMD_LIT)
  `KLZ_ASSERT_NEXT(a_dlo_dhi, clk, rst, accept && st.phase == PH_DLO, st.phase == PH_DHI)
  `KLZ_ASSERT_SAME(a_flags_bound, clk, rst, 1'b1, st.flags_left <= 5'd16)

endmodule

// ===== hdl/klz_back.sv =====
// Copy engine: executes parser commands through the history window and packs results.
// Depends on klz_pkg and on the assertion macros of assert_macros.svh.
`include "assert_macros.svh"

module klz_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_empty,
  input  klz_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output klz_pkg::res_t res
);

  import klz_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [WIN_AW-1:0] wp;
  logic [WIN_AW-1:0] wp_next;
  logic [WIN_AW-1:0] src_off;
  logic [WIN_AW-1:0] src_off_next;
  logic [WIN_AW-1:0] rd_addr;
  logic [LEN_W-1:0]  remaining;
  logic [LEN_W-1:0]  remaining_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [7:0]        pack [0:BYTES_PER_RESULT-1];
  logic              pack_we;
  logic [7:0]        rd_data;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic              emit;

  logic [7:0] window [0:WIN_SIZE-1];

  assign rd_addr = wp + src_off;

  // Command execution and result packing.
  always_comb begin
    state_next     = state;
    wp_next        = wp;
    src_off_next   = src_off;
    remaining_next = remaining;
    fill_next      = fill;
    pack_we        = 1'b0;
    mem_we         = 1'b0;
    mem_wdata      = rd_data;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    res            = '0;
    emit           = (fill == FILL_W'(BYTES_PER_RESULT - 1)) || (remaining == 9'd1);
    unique case (state)
      S_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_LIT: begin
              mem_we      = 1'b1;
              mem_wdata   = cmd.data;
              wp_next     = wp + 1'b1;
              res_push    = 1'b1;
              res.data[0] = cmd.data;
              res.count   = 3'd1;
              res.last    = 1'b1;
            end
            CMD_COPY: begin
              src_off_next   = cmd.offset;
              remaining_next = cmd.length;
              fill_next      = '0;
              state_next     = S_READ;
            end
            CMD_END: begin
              res_push       = 1'b1;
              res.last       = 1'b1;
              res.stream_end = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (!(emit && res_full)) begin
          mem_we         = 1'b1;
          wp_next        = wp + 1'b1;
          remaining_next = remaining - 9'd1;
          if (emit) begin
            res_push = 1'b1;
            for (int i = 0; i < BYTES_PER_RESULT; i++) begin
              if (FILL_W'(i) < fill) begin
                res.data[i] = pack[i];
              end else if (FILL_W'(i) == fill) begin
                res.data[i] = rd_data;
              end
            end
            res.count = {1'b0, fill} + 3'd1;
            res.last  = (remaining == 9'd1);
            fill_next = '0;
          end else begin
            pack_we   = 1'b1;
            fill_next = fill + 1'b1;
          end
          state_next = (remaining == 9'd1) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // History window: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      window[wp] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_data <= window[rd_addr];
    end
  end

  // Partly filled result word.
  always_ff @(posedge clk) begin
    if (pack_we) begin
      pack[fill] <= rd_data;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      remaining <= '0;
      fill      <= '0;
    end else begin
      state     <= state_next;
      wp        <= wp_next;
      remaining <= remaining_next;
      fill      <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    src_off <= src_off_next;
  end

  `KLZ_ASSERT_SAME(a_push_room, clk, rst, res_push, !res_full)
  `KLZ_ASSERT_SAME(a_copy_left, clk, rst, state == S_WRITE, remaining != 9'd0)
  `KLZ_ASSERT_SAME(a_full_word, clk, rst, res_push && !res.last, res.count == 3'd4)

endmodule

// ===== hdl/kosinski_lz_decompressor.sv =====
// Kosinski decompressor: one compressed byte goes in per item, and up to four
// decompressed bytes come out per result item. The parser takes one byte per
// cycle and stalls only while its command queue is full. The copy engine
// takes a literal or a stream end in the idle state and pushes its result as it
// pops the command. A match is taken in the idle state; then each copied byte
// is read from the 8 KiB window RAM and then written back. A result push waits
// for room in the result queue, and no new command is taken until a match is
// done, so the copy engine throttles sustained input. No clearing pass follows
// reset; the first item may be taken in the first cycle after reset.
// Depends on klz_pkg, klz_front, klz_fifo and klz_back.

module kosinski_lz_decompressor #(
  parameter int CMD_DEPTH = klz_pkg::CMD_DEPTH_DEFAULT,
  parameter int RES_DEPTH = klz_pkg::RES_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte0,
  output logic [7:0] out_byte1,
  output logic [7:0] out_byte2,
  output logic [7:0] out_byte3,
  output logic [2:0] byte_count,
  output logic       last_of_run,
  output logic       stream_end
);

  import klz_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  res_t res_in;
  res_t res_out;
  logic res_push;
  logic res_full;

  // Parser.
  klz_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_byte  (in_byte),
    .full     (full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // Command queue between parser and copy engine.
  klz_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // Copy engine.
  klz_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue towards the consumer.
  klz_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  // Result fields.
  assign out_byte0   = res_out.data[0];
  assign out_byte1   = res_out.data[1];
  assign out_byte2   = res_out.data[2];
  assign out_byte3   = res_out.data[3];
  assign byte_count  = res_out.count;
  assign last_of_run = res_out.last;
  assign stream_end  = res_out.stream_end;

endmodule
